>>> hw/rtl/srrw_pkg.sv
`default_nettype none
package srrw_pkg;

  localparam int SeqW    = 32;
  localparam int LenW    = 11;
  localparam int HandleW = 16;
  localparam int WinW    = 6;
  localparam int CfgIdxW = 1;

  localparam int SegSize  = 1024;
  localparam int SegShift = $clog2(SegSize);
  localparam int OffW     = SeqW - SegShift;

  localparam logic [SeqW-1:0] InitSeqReset = 32'd127;
  localparam logic [WinW-1:0] WinReset     = 6'd32;

  localparam logic [CfgIdxW-1:0] CfgInitSeq = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWindow  = 1'b1;

  localparam logic KindAck     = 1'b0;
  localparam logic KindDeliver = 1'b1;

  typedef struct packed {
    logic [SeqW-1:0]    seq;
    logic [LenW-1:0]    len;
    logic               fin;
    logic [HandleW-1:0] handle;
  } seg_t;

  typedef struct packed {
    logic valid;
    seg_t seg;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0]    len;
    logic [HandleW-1:0] handle;
    logic               fin;
  } entry_t;

  typedef struct packed {
    logic               kind;
    logic [SeqW-1:0]    ack;
    logic [HandleW-1:0] handle;
    logic               fin;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StClass,
    StRead,
    StDeliver,
    StAck
  } st_e;

endpackage
`default_nettype wire

>>> hw/rtl/srrw_front.sv
`default_nettype none
module srrw_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire srrw_pkg::seg_t seg_i,
  output srrw_pkg::item_t    item_o,
  input  wire logic          pop_i
);
  import srrw_pkg::*;

  seg_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_o.valid = (cnt_q != 2'd0);
  assign item_o.seg   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= seg_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/srrw_engine.sv
`default_nettype none
module srrw_engine #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [srrw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [srrw_pkg::SeqW-1:0]     cfg_data_i,
  input  wire srrw_pkg::item_t               item_i,
  output logic                               pop_o,
  input  wire logic                          out_free_i,
  output logic                               push_o,
  output srrw_pkg::res_t                     res_o
);
  import srrw_pkg::*;

  localparam int HeadW = $clog2(WINDOW_DEPTH);
  localparam logic [WinW-1:0]  DepthW   = WinW'(WINDOW_DEPTH);
  localparam logic [HeadW:0]   DepthH   = (HeadW+1)'(WINDOW_DEPTH);
  localparam logic [HeadW-1:0] LastHead = HeadW'(WINDOW_DEPTH - 1);

  st_e                     state_q, state_d;
  seg_t                    seg_q, seg_d;
  logic [SeqW-1:0]         diff_q, diff_d;
  logic                    old_q, old_d;
  logic [SeqW-1:0]         next_q, next_d;
  logic [HeadW-1:0]        head_q, head_d;
  logic                    finished_q, finished_d;
  logic [WINDOW_DEPTH-1:0] present_q, present_d;
  logic [WinW-1:0]         win_q;
  entry_t                  slot_mem_q [WINDOW_DEPTH];
  entry_t                  rd_q;

  logic [WinW-1:0]  win_eff;
  logic [OffW-1:0]  offset;
  logic             beyond;
  logic [HeadW:0]   sum;
  logic [HeadW:0]   sum_wrap;
  logic [HeadW-1:0] slot;
  logic [HeadW-1:0] head_inc;
  logic             mem_we;
  logic             rd_en;
  logic             restart;

  assign win_eff  = (win_q == '0 || win_q > DepthW) ? DepthW : win_q;
  assign offset   = diff_q[SeqW-1:SegShift];
  assign beyond   = offset >= OffW'(win_eff);
  assign sum      = (HeadW+1)'(head_q) + (HeadW+1)'(offset[HeadW-1:0]);
  assign sum_wrap = (sum >= DepthH) ? sum - DepthH : sum;
  assign slot     = sum_wrap[HeadW-1:0];
  assign head_inc = (head_q == LastHead) ? '0 : head_q + HeadW'(1);
  assign restart  = cfg_we_i && (cfg_index_i == CfgInitSeq);

  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    diff_d     = diff_q;
    old_d      = old_q;
    next_d     = next_q;
    head_d     = head_q;
    finished_d = finished_q;
    present_d  = present_q;
    pop_o      = 1'b0;
    push_o     = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    res_o      = '0;
    case (state_q)
      StIdle: begin
        if (item_i.valid) begin
          pop_o   = 1'b1;
          seg_d   = item_i.seg;
          diff_d  = item_i.seg.seq - next_q;
          old_d   = item_i.seg.seq < next_q;
          state_d = StClass;
        end
      end
      StClass: begin
        if (finished_q) begin
          state_d = StIdle;
        end else if (old_q) begin
          state_d = StAck;
        end else if (beyond) begin
          state_d = StIdle;
        end else begin
          mem_we          = 1'b1;
          present_d[slot] = 1'b1;
          state_d         = StRead;
        end
      end
      StRead: begin
        if (present_q[head_q]) begin
          rd_en   = 1'b1;
          state_d = StDeliver;
        end else begin
          state_d = StAck;
        end
      end
      StDeliver: begin
        res_o.kind   = KindDeliver;
        res_o.handle = rd_q.handle;
        res_o.fin    = rd_q.fin;
        if (out_free_i) begin
          push_o            = 1'b1;
          next_d            = next_q + SeqW'(rd_q.len);
          present_d[head_q] = 1'b0;
          head_d            = head_inc;
          if (rd_q.fin) begin
            finished_d = 1'b1;
            state_d    = StAck;
          end else begin
            state_d = StRead;
          end
        end
      end
      StAck: begin
        res_o.kind = KindAck;
        res_o.ack  = next_q;
        res_o.last = 1'b1;
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      next_q     <= InitSeqReset;
      head_q     <= '0;
      finished_q <= 1'b0;
      present_q  <= '0;
      win_q      <= WinReset;
    end else begin
      state_q <= state_d;
      if (restart) begin
        next_q     <= cfg_data_i;
        head_q     <= '0;
        finished_q <= 1'b0;
        present_q  <= '0;
      end else begin
        next_q     <= next_d;
        head_q     <= head_d;
        finished_q <= finished_d;
        present_q  <= present_d;
      end
      if (cfg_we_i && cfg_index_i == CfgWindow) begin
        win_q <= cfg_data_i[WinW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    diff_q <= diff_d;
    old_q  <= old_d;
    if (mem_we) begin
      slot_mem_q[slot] <= '{len: seg_q.len, handle: seg_q.handle, fin: seg_q.fin};
    end
    if (rd_en) begin
      rd_q <= slot_mem_q[head_q];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/srrw_outreg.sv
`default_nettype none
module srrw_outreg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire srrw_pkg::res_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output srrw_pkg::res_t      res_o
);
  import srrw_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/selective_repeat_receive_window_top.sv
// Selective-repeat receive window. Segment headers enter a two-word queue and are
// handled one at a time by a sequencer that classifies each against the next expected
// sequence number, marks it in a ring of WINDOW_DEPTH slots and walks the in-order
// slots. A stored segment is written to its slot; then each in-order slot is read and
// delivered until a gap or a fin segment ends the walk, and an ack follows. An old
// segment gets only an ack, a dropped one no result. The walk is bound by the
// registered read of the slot memory, one slot per read. Results leave through one
// output register, so the next result is built while the previous one waits. Writing
// initial_sequence restarts the receiver and clears all slots in the same cycle.
`default_nettype none
module selective_repeat_receive_window_top #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [srrw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [srrw_pkg::SeqW-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [srrw_pkg::SeqW-1:0]      seq_number_i,
  input  wire logic [srrw_pkg::LenW-1:0]      seg_length_i,
  input  wire logic                           fin_flag_i,
  input  wire logic [srrw_pkg::HandleW-1:0]   payload_handle_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [srrw_pkg::SeqW-1:0]           ack_number_o,
  output logic [srrw_pkg::HandleW-1:0]        delivered_handle_o,
  output logic                                delivered_fin_o,
  output logic                                last_o
);
  import srrw_pkg::*;

  seg_t  seg_in;
  item_t item;
  logic  pop;
  logic  push;
  logic  out_free;
  res_t  res_eng;
  res_t  res_out;

  assign seg_in = '{seq: seq_number_i, len: seg_length_i, fin: fin_flag_i,
                    handle: payload_handle_i};

  srrw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .seg_i      (seg_in),
    .item_o     (item),
    .pop_i      (pop)
  );

  srrw_engine #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .pop_o       (pop),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res_eng)
  );

  srrw_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_eng),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o             = res_out.kind;
  assign ack_number_o       = res_out.ack;
  assign delivered_handle_o = res_out.handle;
  assign delivered_fin_o    = res_out.fin;
  assign last_o             = res_out.last;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free) else $error("result pushed into a full output register");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item.valid) else $error("queue popped while empty");

  a_deliver_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindDeliver) |-> (!last_o && ack_number_o == '0))
    else $error("delivery word marked last or carries an ack number");

  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindAck) |-> (last_o && delivered_handle_o == '0 &&
    !delivered_fin_o)) else $error("ack word malformed");

endmodule
`default_nettype wire

>>> tb/tb_selective_repeat_receive_window_top.sv
`default_nettype none
import srrw_pkg::*;

class reassembly_board;
  localparam int Depth = 32;

  logic [SeqW-1:0] init_seq;
  logic [WinW-1:0] win_slots;
  logic [SeqW-1:0] next_exp;
  logic [4:0]      head;
  logic            present [Depth];
  entry_t          slots [Depth];
  bit              finished;
  res_t            due_words[$];
  int              mismatches;

  function new();
    init_seq   = InitSeqReset;
    win_slots  = WinReset;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    next_exp = init_seq;
    head     = '0;
    finished = 1'b0;
    foreach (present[i]) present[i] = 1'b0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [SeqW-1:0] val);
    if (idx == CfgInitSeq) begin
      init_seq = val;
      restart();
    end else begin
      win_slots = val[WinW-1:0];
    end
  endfunction

  function int unsigned eff_window();
    if (win_slots == 0 || win_slots > Depth) return Depth;
    return win_slots;
  endfunction

  function void push_word(logic kind, logic [SeqW-1:0] ack, logic [HandleW-1:0] handle,
                          logic fin, logic last);
    res_t w;
    w.kind   = kind;
    w.ack    = ack;
    w.handle = handle;
    w.fin    = fin;
    w.last   = last;
    due_words.insert(due_words.size(), w);
  endfunction

  function void take_segment(seg_t s);
    logic [SeqW-1:0] off;
    logic [4:0]      slot;
    logic            fin_hit;
    int              n;
    if (finished) return;
    if (s.seq < next_exp) begin
      push_word(KindAck, next_exp, '0, 1'b0, 1'b1);
      return;
    end
    off = (s.seq - next_exp) >> SegShift;
    if (off >= eff_window()) return;
    slot = head + off[4:0];
    present[slot]      = 1'b1;
    slots[slot].len    = s.len;
    slots[slot].handle = s.handle;
    slots[slot].fin    = s.fin;
    n = 0;
    while (n < Depth && present[head]) begin
      push_word(KindDeliver, '0, slots[head].handle, slots[head].fin, 1'b0);
      n++;
      next_exp      = next_exp + SeqW'(slots[head].len);
      present[head] = 1'b0;
      fin_hit       = slots[head].fin;
      head          = head + 5'd1;
      if (fin_hit) begin
        finished = 1'b1;
        break;
      end
    end
    push_word(KindAck, next_exp, '0, 1'b0, 1'b1);
  endfunction

  function void check_word(res_t got);
    res_t want;
    if (due_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: kind %0d ack %h handle %h fin %0d last %0d",
                 got.kind, got.ack, got.handle, got.fin, got.last);
      return;
    end
    want = due_words.pop_front();
    if (got.kind !== want.kind || got.ack !== want.ack || got.handle !== want.handle ||
        got.fin !== want.fin || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected kind %0d ack %h handle %h fin %0d last %0d",
                 want.kind, want.ack, want.handle, want.fin, want.last,
                 ", got kind %0d ack %h handle %h fin %0d last %0d",
                 got.kind, got.ack, got.handle, got.fin, got.last);
    end
  endfunction
endclass

module tb_selective_repeat_receive_window_top;
  localparam int DrainCycles = 40;
  localparam int ItemsPerPhase = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [SeqW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SeqW-1:0]     seq_number_i;
  logic [LenW-1:0]     seg_length_i;
  logic                fin_flag_i;
  logic [HandleW-1:0]  payload_handle_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                kind_o;
  logic [SeqW-1:0]     ack_number_o;
  logic [HandleW-1:0]  delivered_handle_o;
  logic                delivered_fin_o;
  logic                last_o;

  reassembly_board sb;
  int unsigned     send_idle;
  int unsigned     recv_idle;
  int              hold_left;

  selective_repeat_receive_window_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver side
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind   = kind_o;
      got.ack    = ack_number_o;
      got.handle = delivered_handle_o;
      got.fin    = delivered_fin_o;
      got.last   = last_o;
      sb.check_word(got);
    end
  end

  function automatic seg_t mk(logic [SeqW-1:0] seq, logic [LenW-1:0] len, logic fin,
                              logic [HandleW-1:0] handle);
    seg_t s;
    s.seq    = seq;
    s.len    = len;
    s.fin    = fin;
    s.handle = handle;
    return s;
  endfunction

  task automatic send_seg(seg_t s);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    seq_number_i     <= s.seq;
    seg_length_i     <= s.len;
    fin_flag_i       <= s.fin;
    payload_handle_i <= s.handle;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_segment(s);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SeqW-1:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic pick_segment(output seg_t s);
    int unsigned     roll;
    int unsigned     win;
    int unsigned     off;
    logic [SeqW-1:0] base;
    roll     = $urandom_range(99);
    win      = sb.eff_window();
    base     = sb.next_exp;
    s.handle = HandleW'($urandom);
    s.fin    = ($urandom_range(99) < 3);
    s.len    = ($urandom_range(3) == 0) ? LenW'($urandom_range(1024)) : LenW'(SegSize);
    if (roll < 70) begin
      off   = ($urandom_range(2) == 0) ? 0 : $urandom_range(win - 1);
      s.seq = base + off * SegSize;
      if ($urandom_range(3) == 0) s.seq = s.seq + $urandom_range(SegSize - 1);
    end else if (roll < 80) begin
      s.seq = (base == 0) ? $urandom : $urandom_range(base - 1, 0);
    end else if (roll < 88) begin
      s.seq = base + win * SegSize + $urandom_range(SegSize * 8);
    end else begin
      s.seq = $urandom;
      s.len = LenW'($urandom_range(1024));
      s.fin = 1'($urandom_range(1));
    end
  endtask

  // offsets from the far end of the window down to zero, one walk over all of it
  task automatic fill_window_reverse();
    logic [SeqW-1:0] base;
    int              k;
    base = sb.next_exp;
    for (k = int'(sb.eff_window()) - 1; k >= 0; k--)
      send_seg(mk(base + k * SegSize, LenW'(SegSize), 1'b0, HandleW'($urandom)));
  endtask

  initial begin
    seg_t s;
    int   phase;
    int   n;
    sb               = new();
    send_idle        = 37;
    recv_idle        = 64;
    hold_left        = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CfgInitSeq;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    seq_number_i     = '0;
    seg_length_i     = '0;
    fin_flag_i       = 1'b0;
    payload_handle_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // old, beyond window, out of order, overwrite, unaligned, zero length
    send_seg(mk(32'd0, 11'd5, 1'b0, 16'h0001));
    send_seg(mk(32'd127 + 32 * SegSize, 11'd1024, 1'b0, 16'h0002));
    send_seg(mk(32'd127 + 2 * SegSize, 11'd1024, 1'b0, 16'h0003));
    send_seg(mk(32'd127 + SegSize, 11'd1024, 1'b0, 16'h0004));
    send_seg(mk(32'd127 + SegSize + 100, 11'd1024, 1'b0, 16'h0005));
    send_seg(mk(32'd127 + 1023, 11'd1024, 1'b0, 16'hFFFF));
    send_seg(mk(32'd3199, 11'd0, 1'b0, 16'h0000));
    send_seg(mk(32'd3199, 11'd1024, 1'b0, 16'h0007));
    send_seg(mk(32'hFFFF_FFFF, 11'd1024, 1'b0, 16'h0008));
    // fin in the middle of a walk leaves a later slot behind
    send_seg(mk(32'd4223 + SegSize, 11'd1024, 1'b1, 16'h0009));
    send_seg(mk(32'd4223 + 2 * SegSize, 11'd500, 1'b0, 16'h000A));
    send_seg(mk(32'd4223, 11'd1024, 1'b0, 16'h000B));
    send_seg(mk(32'd6271, 11'd1024, 1'b0, 16'h000C));
    send_seg(mk(32'd0, 11'd0, 1'b0, 16'h0000));
    // sequence wrap
    write_reg(CfgInitSeq, 32'hFFFF_FC00);
    send_seg(mk(32'hFFFF_FC00, 11'd1024, 1'b0, 16'h000D));
    send_seg(mk(32'h0000_0400, 11'd1024, 1'b0, 16'h000E));
    write_reg(CfgWindow, 32'd1);
    send_seg(mk(32'h0000_0400, 11'd1024, 1'b0, 16'h00F0));
    send_seg(mk(32'h0000_0000, 11'd1024, 1'b0, 16'h000F));
    write_reg(CfgWindow, 32'd0);
    write_reg(CfgInitSeq, 32'hFFFF_FFFF);
    send_seg(mk(32'hFFFF_FFFE, 11'd7, 1'b0, 16'h0010));
    send_seg(mk(32'hFFFF_FFFF, 11'd1024, 1'b1, 16'h0011));
    write_reg(CfgWindow, 32'd63);
    write_reg(CfgInitSeq, 32'd0);
    send_seg(mk(32'd0, 11'd1024, 1'b0, 16'h0012));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 37;
          recv_idle = 64;
          write_reg(CfgWindow, $urandom_range(31, 2));
          write_reg(CfgInitSeq, $urandom);
        end
        1: begin
          send_idle = 64;
          recv_idle = 37;
          write_reg(CfgWindow, 32'd32);
          write_reg(CfgInitSeq, 32'hFFFF_0000 + $urandom_range(16'hFFFF));
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(CfgWindow, $urandom_range(63));
          write_reg(CfgInitSeq, $urandom_range(5000));
        end
      endcase
      if (phase == 0) hold_left = 300;
      fill_window_reverse();
      n = 0;
      while (n < ItemsPerPhase) begin
        if (sb.finished) begin
          pick_segment(s);
          send_seg(s);
          write_reg(CfgInitSeq, $urandom);
        end
        pick_segment(s);
        send_seg(s);
        n++;
        if (phase == 1 && n == ItemsPerPhase / 2) wait_drained();
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
